@@ design/cfar_pd_pkg.sv @@
// Shared types and codes for the CFAR pixel detector.
// Used by cfar_pd_ctrl, cfar_pd_dp and block_cfar_pixel_detector_top.
package cfar_pd_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        REG_ROWS  = 3'd0,
        REG_COLS  = 3'd1,
        REG_TRAIN = 3'd2,
        REG_GUARD = 3'd3,
        REG_BLOCK = 3'd4,
        REG_ALPHA = 3'd5
    } t_reg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RDM,
        S_CLEAR,
        S_LIM,
        S_CHECK,
        S_SCAN,
        S_TAIL,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_PATCH,
        S_DONE
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 12;

    localparam logic [8:0]  RST_ROWS  = 9'd256;
    localparam logic [8:0]  RST_COLS  = 9'd256;
    localparam logic [5:0]  RST_TRAIN = 6'd8;
    localparam logic [4:0]  RST_GUARD = 5'd4;
    localparam logic [5:0]  RST_BLOCK = 6'd4;
    localparam logic [15:0] RST_ALPHA = 16'd3188;

    typedef struct packed {
        logic take;
        logic rd_done;
        logic run_done;
        logic run_init;
        logic clr_step;
        logic lim_step;
        logic scan_init;
        logic scan_step;
        logic diff_en;
        logic mul_en;
        logic patch_init;
        logic patch_step;
        logic grid_step;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic clr_last;
        logic lim_done;
        logic center_ok;
        logic scan_last;
        logic hit;
        logic patch_last;
    } t_status;

endpackage

@@ design/cfar_pd_ctrl.sv @@
// Sequencer for the CFAR pixel detector: request handshake and run walk.
// Depends on cfar_pd_pkg; drives the commands of cfar_pd_dp.
module cfar_pd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  logic [1:0]           i_opcode,
    input  cfar_pd_pkg::t_status i_status,
    output logic                 o_in_ready,
    output cfar_pd_pkg::t_cmd    o_cmd
);

    cfar_pd_pkg::t_state r_state, n_state;
    logic w_ready;
    logic w_take;

    assign w_ready    = (r_state == cfar_pd_pkg::S_IDLE) &&
                        (!i_status.out_valid || i_out_ready);
    assign w_take     = w_ready && i_in_valid;
    assign o_in_ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfar_pd_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cfar_pd_pkg::S_INIT: begin
                if (i_status.clr_last) n_state = cfar_pd_pkg::S_IDLE;
            end
            cfar_pd_pkg::S_IDLE: begin
                if (w_take) begin
                    case (cfar_pd_pkg::t_op'(i_opcode))
                        cfar_pd_pkg::OP_READ: n_state = cfar_pd_pkg::S_RDM;
                        cfar_pd_pkg::OP_RUN:  n_state = cfar_pd_pkg::S_CLEAR;
                        default:              n_state = cfar_pd_pkg::S_IDLE;
                    endcase
                end
            end
            cfar_pd_pkg::S_RDM:   n_state = cfar_pd_pkg::S_IDLE;
            cfar_pd_pkg::S_CLEAR: begin
                if (i_status.clr_last) n_state = cfar_pd_pkg::S_LIM;
            end
            cfar_pd_pkg::S_LIM: begin
                if (i_status.lim_done) n_state = cfar_pd_pkg::S_CHECK;
            end
            cfar_pd_pkg::S_CHECK: begin
                n_state = i_status.center_ok ? cfar_pd_pkg::S_SCAN : cfar_pd_pkg::S_DONE;
            end
            cfar_pd_pkg::S_SCAN: begin
                if (i_status.scan_last) n_state = cfar_pd_pkg::S_TAIL;
            end
            cfar_pd_pkg::S_TAIL:  n_state = cfar_pd_pkg::S_DIFF;
            cfar_pd_pkg::S_DIFF:  n_state = cfar_pd_pkg::S_MUL;
            cfar_pd_pkg::S_MUL:   n_state = cfar_pd_pkg::S_CMP;
            cfar_pd_pkg::S_CMP: begin
                n_state = i_status.hit ? cfar_pd_pkg::S_PATCH : cfar_pd_pkg::S_CHECK;
            end
            cfar_pd_pkg::S_PATCH: begin
                if (i_status.patch_last) n_state = cfar_pd_pkg::S_CHECK;
            end
            cfar_pd_pkg::S_DONE:  n_state = cfar_pd_pkg::S_IDLE;
            default:              n_state = cfar_pd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            cfar_pd_pkg::S_INIT:  o_cmd.clr_step = 1'b1;
            cfar_pd_pkg::S_IDLE: begin
                o_cmd.take     = w_take;
                o_cmd.run_init = w_take &&
                                 (cfar_pd_pkg::t_op'(i_opcode) == cfar_pd_pkg::OP_RUN);
            end
            cfar_pd_pkg::S_RDM:   o_cmd.rd_done  = 1'b1;
            cfar_pd_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            cfar_pd_pkg::S_LIM:   o_cmd.lim_step = 1'b1;
            cfar_pd_pkg::S_CHECK: o_cmd.scan_init = i_status.center_ok;
            cfar_pd_pkg::S_SCAN:  o_cmd.scan_step = 1'b1;
            cfar_pd_pkg::S_DIFF:  o_cmd.diff_en  = 1'b1;
            cfar_pd_pkg::S_MUL:   o_cmd.mul_en   = 1'b1;
            cfar_pd_pkg::S_CMP: begin
                o_cmd.patch_init = i_status.hit;
                o_cmd.grid_step  = !i_status.hit;
            end
            cfar_pd_pkg::S_PATCH: begin
                o_cmd.patch_step = 1'b1;
                o_cmd.grid_step  = i_status.patch_last;
            end
            cfar_pd_pkg::S_DONE:  o_cmd.run_done = 1'b1;
            default:              o_cmd = '0;
        endcase
    end

endmodule

@@ design/cfar_pd_dp.sv @@
// Datapath of the CFAR pixel detector: registers, frame and mask stores,
// window sums, threshold test and patch writer. Depends on cfar_pd_pkg.
module cfar_pd_dp #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int MAX_WINDOW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cfar_pd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfar_pd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                          i_opcode,
    input  logic [7:0]                          i_row,
    input  logic [7:0]                          i_col,
    input  logic [7:0]                          i_hue,
    input  logic                                i_out_ready,
    input  cfar_pd_pkg::t_cmd                   i_cmd,
    output cfar_pd_pkg::t_status                o_status,
    output logic                                o_out_valid,
    output logic                                o_mask_bit,
    output logic                                o_accepted
);

    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AW    = RB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int XW    = $clog2(MAXD + 4 * MAX_WINDOW + 264) + 1;
    localparam int TW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = $clog2((MAX_WINDOW + 2) * (MAX_WINDOW + 2) * 255 + 1);
    localparam int PW    = 8 + TW;
    localparam int LW    = PW + cfar_pd_pkg::FRAC_BITS;
    localparam int RHW   = cfar_pd_pkg::CFG_DATA_W + SW;
    localparam int CMPW  = (LW > RHW) ? LW : RHW;

    logic [8:0]  r_rows, r_cols;
    logic [5:0]  r_train, r_block;
    logic [4:0]  r_guard;
    logic [15:0] r_alpha;

    logic [7:0] r_frame [DEPTH];
    logic       r_mask  [DEPTH];
    logic [7:0] r_rd;
    logic       r_mask_q;
    logic       r_rd_inside;

    logic                 r_out_valid, r_mask_bit, r_accepted;
    logic [AW-1:0]        r_clr_cnt;
    logic signed [XW-1:0] r_lim_r, r_lim_c, r_i, r_j, r_dx, r_dy, r_pk, r_pl;
    logic                 r_pv, r_pf_in, r_pf_tr, r_pf_gd, r_pf_ctr;
    logic [SW-1:0]        r_st, r_sg, r_diff;
    logic [7:0]           r_ctr;
    logic [PW-1:0]        r_pt;
    logic [LW-1:0]        r_lhs;
    logic [RHW-1:0]       r_rhs;

    logic [TW-1:0]        w_t, w_g, w_b;
    logic signed [XW-1:0] w_nr, w_nc, w_tx, w_side, w_gh, w_h, w_bx, w_bh;
    logic signed [XW-1:0] w_lim_r, w_lim_c, w_x, w_y;
    logic                 w_inside, w_x_in, w_y_in, w_p_in;
    logic [AW-1:0]        w_item_addr, w_scan_addr, w_patch_addr, w_mw_addr;
    logic                 w_mw_en, w_mw_data, w_fw_en, w_load, w_load_bit, w_load_acc;
    logic [7:0]           w_pix;
    cfar_pd_pkg::t_op     w_op;

    // saturated window and frame extents
    assign w_t  = (32'(r_train) > 32'(MAX_WINDOW)) ? TW'(MAX_WINDOW) : TW'(r_train);
    assign w_g  = (32'(r_guard) > 32'(MAX_WINDOW)) ? TW'(MAX_WINDOW) : TW'(r_guard);
    assign w_b  = (32'(r_block) > 32'(MAX_WINDOW)) ? TW'(MAX_WINDOW) :
                  (r_block == 6'd0) ? TW'(1) : TW'(r_block);
    assign w_nr = (32'(r_rows) > 32'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(r_rows);
    assign w_nc = (32'(r_cols) > 32'(MAX_COLS)) ? XW'(MAX_COLS) : XW'(r_cols);
    assign w_tx   = XW'(w_t);
    assign w_side = XW'(w_t >> 1);
    assign w_gh   = XW'(w_g >> 1);
    assign w_h    = (w_side > w_gh) ? w_side : w_gh;
    assign w_bx   = XW'(w_b);
    assign w_bh   = XW'(w_b >> 1);
    assign w_lim_r = (w_t == '0) ? w_nr : r_lim_r;
    assign w_lim_c = (w_t == '0) ? w_nc : r_lim_c;

    assign w_op        = cfar_pd_pkg::t_op'(i_opcode);
    assign w_inside    = (XW'(i_row) < w_nr) && (XW'(i_col) < w_nc);
    assign w_item_addr = {RB'(i_row), CB'(i_col)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= cfar_pd_pkg::RST_ROWS;
            r_cols  <= cfar_pd_pkg::RST_COLS;
            r_train <= cfar_pd_pkg::RST_TRAIN;
            r_guard <= cfar_pd_pkg::RST_GUARD;
            r_block <= cfar_pd_pkg::RST_BLOCK;
            r_alpha <= cfar_pd_pkg::RST_ALPHA;
        end else if (i_cfg_valid) begin
            case (cfar_pd_pkg::t_reg'(i_cfg_index))
                cfar_pd_pkg::REG_ROWS:  r_rows  <= i_cfg_data[8:0];
                cfar_pd_pkg::REG_COLS:  r_cols  <= i_cfg_data[8:0];
                cfar_pd_pkg::REG_TRAIN: r_train <= i_cfg_data[5:0];
                cfar_pd_pkg::REG_GUARD: r_guard <= i_cfg_data[4:0];
                cfar_pd_pkg::REG_BLOCK: r_block <= i_cfg_data[5:0];
                cfar_pd_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window scan address and flags
    assign w_x    = r_i + r_dx;
    assign w_y    = r_j + r_dy;
    assign w_x_in = (w_x >= XW'(0)) && (w_x < w_nr) && (w_y >= XW'(0)) && (w_y < w_nc);
    assign w_scan_addr = {RB'(w_x), CB'(w_y)};

    // patch address
    assign w_p_in = (r_pk >= XW'(0)) && (r_pk < w_nr) && (r_pl >= XW'(0)) && (r_pl < w_nc);
    assign w_patch_addr = {RB'(r_pk), CB'(r_pl)};

    assign w_fw_en   = i_cmd.take && (w_op == cfar_pd_pkg::OP_WRITE) && w_inside;
    assign w_mw_en   = i_cmd.clr_step || (i_cmd.patch_step && w_p_in);
    assign w_mw_addr = i_cmd.clr_step ? r_clr_cnt : w_patch_addr;
    assign w_mw_data = !i_cmd.clr_step;

    always_ff @(posedge i_clk) begin
        if (w_fw_en) r_frame[w_item_addr] <= i_hue;
        r_rd <= r_frame[w_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_mw_en) r_mask[w_mw_addr] <= w_mw_data;
        r_mask_q <= r_mask[w_item_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_pv      <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + AW'(1);
            r_pv <= i_cmd.scan_step;
        end
    end

    // grid limits, centers, scan and patch counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_rd_inside <= w_inside;
        if (i_cmd.run_init) begin
            r_lim_r <= '0;
            r_lim_c <= '0;
            r_i     <= w_side;
            r_j     <= w_side;
        end
        if (i_cmd.lim_step) begin
            if (w_t != '0 && r_lim_r + w_tx <= w_nr) r_lim_r <= r_lim_r + w_tx;
            if (w_t != '0 && r_lim_c + w_tx <= w_nc) r_lim_c <= r_lim_c + w_tx;
        end
        if (i_cmd.grid_step) begin
            if (r_j + w_bx > w_lim_c) begin
                r_j <= w_side;
                r_i <= r_i + w_bx;
            end else begin
                r_j <= r_j + w_bx;
            end
        end
        if (i_cmd.scan_init) begin
            r_dx <= -w_h;
            r_dy <= -w_h;
        end else if (i_cmd.scan_step) begin
            if (r_dy == w_h + XW'(1)) begin
                r_dy <= -w_h;
                r_dx <= r_dx + XW'(1);
            end else begin
                r_dy <= r_dy + XW'(1);
            end
        end
        if (i_cmd.patch_init) begin
            r_pk <= r_i - w_bh;
            r_pl <= r_j - w_bh;
        end else if (i_cmd.patch_step) begin
            if (r_pl == r_j + w_bh) begin
                r_pl <= r_j - w_bh;
                r_pk <= r_pk + XW'(1);
            end else begin
                r_pl <= r_pl + XW'(1);
            end
        end
    end

    // accumulate one window pixel per cycle, in the cycle after its read
    assign w_pix = r_pf_in ? r_rd : 8'd0;

    always_ff @(posedge i_clk) begin
        r_pf_in  <= w_x_in;
        r_pf_tr  <= (r_dx >= -w_side) && (r_dx <= w_side + XW'(1)) &&
                    (r_dy >= -w_side) && (r_dy <= w_side + XW'(1));
        r_pf_gd  <= (r_dx >= -w_gh) && (r_dx <= w_gh + XW'(1)) &&
                    (r_dy >= -w_gh) && (r_dy <= w_gh + XW'(1));
        r_pf_ctr <= (r_dx == XW'(0)) && (r_dy == XW'(0));
        if (i_cmd.scan_init) begin
            r_st  <= '0;
            r_sg  <= '0;
            r_ctr <= '0;
        end else if (r_pv) begin
            if (r_pf_tr)  r_st  <= r_st + SW'(w_pix);
            if (r_pf_gd)  r_sg  <= r_sg + SW'(w_pix);
            if (r_pf_ctr) r_ctr <= w_pix;
        end
        if (i_cmd.diff_en) begin
            r_diff <= (r_st >= r_sg) ? (r_st - r_sg) : (r_sg - r_st);
            r_pt   <= PW'(r_ctr) * PW'(w_t);
        end
        if (i_cmd.mul_en) begin
            r_lhs <= {r_pt, cfar_pd_pkg::FRAC_BITS'(0)};
            r_rhs <= RHW'(r_alpha) * RHW'(r_diff);
        end
    end

    // result register
    assign w_load = (i_cmd.take && w_op != cfar_pd_pkg::OP_READ &&
                     w_op != cfar_pd_pkg::OP_RUN) || i_cmd.rd_done || i_cmd.run_done;

    always_comb begin
        w_load_bit = 1'b0;
        w_load_acc = 1'b0;
        if (i_cmd.rd_done) begin
            w_load_bit = r_rd_inside & r_mask_q;
            w_load_acc = r_rd_inside;
        end else if (i_cmd.run_done) begin
            w_load_acc = 1'b1;
        end else if (w_op == cfar_pd_pkg::OP_WRITE) begin
            w_load_acc = w_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mask_bit <= w_load_bit;
            r_accepted <= w_load_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mask_bit  = r_mask_bit;
    assign o_accepted  = r_accepted;

    assign o_status.out_valid  = r_out_valid;
    assign o_status.clr_last   = (r_clr_cnt == {AW{1'b1}});
    assign o_status.lim_done   = (w_t == '0) ||
                                 ((r_lim_r + w_tx > w_nr) && (r_lim_c + w_tx > w_nc));
    assign o_status.center_ok  = (r_i <= w_lim_r) && (r_j <= w_lim_c);
    assign o_status.scan_last  = (r_dx == w_h + XW'(1)) && (r_dy == w_h + XW'(1));
    assign o_status.hit        = (CMPW'(r_lhs) > CMPW'(r_rhs));
    assign o_status.patch_last = (r_pk == r_i + w_bh) && (r_pl == r_j + w_bh);

endmodule

@@ design/block_cfar_pixel_detector_top.sv @@
// Two-dimensional cell-averaging CFAR detector over a stored hue frame.
// Pixel writes and mask reads take one request each: a write answers in the
// cycle after acceptance and frees the input at once, a read passes through
// S_RDM before its result is loaded and holds the input while in S_RDM, and
// no request is taken while an unread result fills the result register. After
// reset the mask store is swept clear, one entry per cycle over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (65536 at the defaults), before
// the first request is taken. A run request sweeps the mask store the same
// way, then steps the grid limit in strides of train in S_LIM, and for each
// grid center scans a (2h+2)^2 window through the single frame store read
// port, with h the larger of the half training and half guard spans, then
// writes a (2*(block/2)+1)^2 patch into the mask when the center is a detection.
// Depends on cfar_pd_pkg, cfar_pd_ctrl and cfar_pd_dp.
module block_cfar_pixel_detector_top #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int MAX_WINDOW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cfar_pd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfar_pd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [7:0]                          i_row,
    input  logic [7:0]                          i_col,
    input  logic [7:0]                          i_hue,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_mask_bit,
    output logic                                o_accepted
);

    cfar_pd_pkg::t_cmd    w_cmd;
    cfar_pd_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    cfar_pd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_opcode    (i_opcode),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    cfar_pd_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_opcode    (i_opcode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_hue       (i_hue),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_mask_bit  (o_mask_bit),
        .o_accepted  (o_accepted)
    );

`ifndef SYNTHESIS
    a_ready_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("request taken while result slot busy");

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == cfar_pd_pkg::OP_READ) |=> ##1 o_out_valid)
        else $error("mask read gave no result");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == cfar_pd_pkg::OP_RUN) |=> !o_in_ready)
        else $error("request taken during run");

    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == cfar_pd_pkg::OP_WRITE) |=> o_out_valid)
        else $error("pixel write gave no result");
`endif

endmodule

@@ bench/cfar_pd_checker.sv @@
`timescale 1ns / 100ps
// Checker for block_cfar_pixel_detector_top: watches the config, request and
// result channels, predicts every result and compares. Depends on cfar_pd_pkg.
module cfar_pd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [cfar_pd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfar_pd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_opcode,
    input  logic [7:0]                         i_row,
    input  logic [7:0]                         i_col,
    input  logic [7:0]                         i_hue,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_mask_bit,
    input  logic                               i_accepted,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    localparam int DIM = 256;
    localparam int WIN = 32;

    typedef struct packed {
        logic mask_bit;
        logic accepted;
    } t_answer;

    logic [7:0]  pixels [0:DIM*DIM-1];
    logic        marks  [0:DIM*DIM-1];
    logic [8:0]  rows_q, cols_q;
    logic [5:0]  train_q, block_q;
    logic [4:0]  guard_q;
    logic [15:0] alpha_q;
    t_answer     answers [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = answers.size();

    function automatic int sat(int v, int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic longint pixel_at(int r, int c, int nr, int nc);
        if (r < 0 || c < 0 || r >= nr || c >= nc)
            return 0;
        return longint'(pixels[r*DIM + c]);
    endfunction

    function automatic longint window_total(int i, int j, int half, int nr, int nc);
        longint s;
        s = 0;
        for (int x = i - half; x <= i + half + 1; x++)
            for (int y = j - half; y <= j + half + 1; y++)
                s += pixel_at(x, y, nr, nc);
        return s;
    endfunction

    task automatic detect_frame();
        int nr, nc, t, g, b, lim_r, lim_c, side, bh;
        longint sg, st, diff, lhs, rhs;
        nr = sat(int'(rows_q), DIM);
        nc = sat(int'(cols_q), DIM);
        t  = sat(int'(train_q), WIN);
        g  = sat(int'(guard_q), WIN);
        b  = sat(int'(block_q), WIN);
        if (b == 0)
            b = 1;
        lim_r = nr;
        lim_c = nc;
        if (t > 0) begin
            lim_r = nr - nr % t;
            lim_c = nc - nc % t;
        end
        side = t / 2;
        bh = b / 2;
        foreach (marks[k])
            marks[k] = 1'b0;
        for (int i = side; i <= lim_r; i += b)
            for (int j = side; j <= lim_c; j += b) begin
                sg = window_total(i, j, g / 2, nr, nc);
                st = window_total(i, j, side, nr, nc);
                diff = (st >= sg) ? st - sg : sg - st;
                lhs = pixel_at(i, j, nr, nc) * longint'(t) * 4096;
                rhs = longint'(alpha_q) * diff;
                if (lhs > rhs)
                    for (int k = i - bh; k <= i + bh; k++)
                        for (int l = j - bh; l <= j + bh; l++)
                            if (k >= 0 && l >= 0 && k < nr && l < nc)
                                marks[k*DIM + l] = 1'b1;
            end
    endtask

    initial begin
        fails = 0;
        foreach (pixels[k])
            pixels[k] = 8'd0;
    end

    always @(posedge i_clk) begin
        t_answer got, want;
        t_answer fresh;
        logic in_frame;
        if (!i_rst_n) begin
            rows_q  <= cfar_pd_pkg::RST_ROWS;
            cols_q  <= cfar_pd_pkg::RST_COLS;
            train_q <= cfar_pd_pkg::RST_TRAIN;
            guard_q <= cfar_pd_pkg::RST_GUARD;
            block_q <= cfar_pd_pkg::RST_BLOCK;
            alpha_q <= cfar_pd_pkg::RST_ALPHA;
            foreach (marks[k])
                marks[k] = 1'b0;
            answers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{mask_bit: i_mask_bit, accepted: i_accepted};
                if (answers.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with nothing pending: %0b %0b",
                                 $time, got.mask_bit, got.accepted);
                end else begin
                    want = answers.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected mask_bit=%0b accepted=%0b, got %0b %0b",
                                     $time, want.mask_bit, want.accepted,
                                     got.mask_bit, got.accepted);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cfar_pd_pkg::REG_ROWS:  rows_q  <= i_cfg_data[8:0];
                    cfar_pd_pkg::REG_COLS:  cols_q  <= i_cfg_data[8:0];
                    cfar_pd_pkg::REG_TRAIN: train_q <= i_cfg_data[5:0];
                    cfar_pd_pkg::REG_GUARD: guard_q <= i_cfg_data[4:0];
                    cfar_pd_pkg::REG_BLOCK: block_q <= i_cfg_data[5:0];
                    cfar_pd_pkg::REG_ALPHA: alpha_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                in_frame = (int'(i_row) < sat(int'(rows_q), DIM))
                        && (int'(i_col) < sat(int'(cols_q), DIM));
                fresh = '0;
                case (i_opcode)
                    cfar_pd_pkg::OP_WRITE: begin
                        if (in_frame) begin
                            pixels[int'(i_row)*DIM + int'(i_col)] = i_hue;
                            fresh.accepted = 1'b1;
                        end
                    end
                    cfar_pd_pkg::OP_RUN: begin
                        detect_frame();
                        fresh.accepted = 1'b1;
                    end
                    cfar_pd_pkg::OP_READ: begin
                        if (in_frame) begin
                            fresh.mask_bit = marks[int'(i_row)*DIM + int'(i_col)];
                            fresh.accepted = 1'b1;
                        end
                    end
                    default: ;
                endcase
                answers.insert(answers.size(), fresh);
            end
        end
    end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for block_cfar_pixel_detector_top: clock, reset, config and
// request stimulus, result backpressure and verdict. Depends on cfar_pd_pkg, cfar_pd_checker.
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [cfar_pd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [cfar_pd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [1:0]                         i_opcode;
    logic [7:0]                         i_row, i_col, i_hue;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic                               o_mask_bit, o_accepted;
    int                                 fail_count, pending;
    int                                 burst_left;
    bit                                 long_hold;

    block_cfar_pixel_detector_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_row(i_row), .i_col(i_col), .i_hue(i_hue),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_mask_bit(o_mask_bit), .o_accepted(o_accepted)
    );

    cfar_pd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_row(i_row), .i_col(i_col), .i_hue(i_hue),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_mask_bit(o_mask_bit), .i_accepted(o_accepted),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: changing stall pattern, plus one long hold-off on request
    initial begin
        int mode, left, hold;
        bit held;
        i_out_ready = 1'b0;
        mode = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
                        input logic [7:0] h);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_row <= r;
        i_col <= c;
        i_hue <= h;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input cfar_pd_pkg::t_reg idx, input logic [15:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic detect_phase(input int nr, input int nc, input int t, input int g,
                                input int b, input int alpha, input bit read_all);
        logic [7:0] h;
        write_reg(cfar_pd_pkg::REG_ROWS, 16'(nr));
        write_reg(cfar_pd_pkg::REG_COLS, 16'(nc));
        write_reg(cfar_pd_pkg::REG_TRAIN, 16'(t));
        write_reg(cfar_pd_pkg::REG_GUARD, 16'(g));
        write_reg(cfar_pd_pkg::REG_BLOCK, 16'(b));
        write_reg(cfar_pd_pkg::REG_ALPHA, 16'(alpha));
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
                case ($urandom_range(0, 9))
                    0: h = 8'd0;
                    1: h = 8'd255;
                    default: h = 8'($urandom_range(0, 255));
                endcase
                send(cfar_pd_pkg::OP_WRITE, 8'(r), 8'(c), h);
                if ($urandom_range(0, 29) == 0)
                    send(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            end
        send(cfar_pd_pkg::OP_WRITE, 8'(nr + $urandom_range(0, 255 - nr)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send(cfar_pd_pkg::OP_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (read_all || $urandom_range(0, 3) == 0)
                    send(cfar_pd_pkg::OP_READ, 8'(r), 8'(c), 8'($urandom_range(0, 255)));
        send(cfar_pd_pkg::OP_READ, 8'($urandom_range(0, 255)),
             8'(nc + $urandom_range(0, 255 - nc)), 8'd0);
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = cfar_pd_pkg::OP_WRITE;
        i_row = '0;
        i_col = '0;
        i_hue = '0;
        burst_left = 0;
        long_hold = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(cfar_pd_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0);
        send(cfar_pd_pkg::OP_WRITE, 8'd255, 8'd255, 8'd255);
        send(cfar_pd_pkg::OP_WRITE, 8'd0, 8'd255, 8'hA5);
        send(cfar_pd_pkg::OP_WRITE, 8'd255, 8'd0, 8'h5A);
        send(cfar_pd_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
        send(cfar_pd_pkg::OP_READ, 8'd255, 8'd255, 8'd255);
        send(cfar_pd_pkg::OP_READ, 8'd128, 8'd127, 8'd0);
        send(OP_UNUSED, 8'd255, 8'd255, 8'd255);
        send(OP_UNUSED, 8'd0, 8'd0, 8'd0);
        write_reg(cfar_pd_pkg::REG_ROWS, 16'd1);
        write_reg(cfar_pd_pkg::REG_COLS, 16'hFFFF);
        send(cfar_pd_pkg::OP_WRITE, 8'd0, 8'd200, 8'd17);
        send(cfar_pd_pkg::OP_WRITE, 8'd1, 8'd0, 8'd17);
        send(cfar_pd_pkg::OP_READ, 8'd1, 8'd5, 8'd0);
        send(cfar_pd_pkg::OP_READ, 8'd0, 8'd255, 8'd0);
        write_reg(cfar_pd_pkg::REG_ROWS, 16'd0);
        send(cfar_pd_pkg::OP_WRITE, 8'd0, 8'd0, 8'd9);
        send(cfar_pd_pkg::OP_READ, 8'd0, 8'd0, 8'd0);

        detect_phase(12, 12, 8, 4, 4, 3188, 1'b0);
        detect_phase(8, 8, 2, 0, 1, 0, 1'b1);
        detect_phase(10, 16, 63, 31, 63, 65535, 1'b0);
        detect_phase(6, 6, 0, 2, 0, $urandom_range(0, 65535), 1'b1);
        detect_phase(11, 11, 5, 7, 6, $urandom_range(0, 4096), 1'b0);
        detect_phase(16, 16, 16, 30, 20, $urandom_range(0, 2048), 1'b0);
        detect_phase(9, 9, 33, 1, 3, 512, 1'b0);
        repeat (3)
            detect_phase($urandom_range(3, 10), $urandom_range(3, 10), $urandom_range(2, 8),
                         $urandom_range(0, 8), $urandom_range(1, 6), $urandom_range(0, 6000),
                         1'b0);

        write_reg(cfar_pd_pkg::REG_ROWS, 16'd256);
        write_reg(cfar_pd_pkg::REG_COLS, 16'd256);
        n = 0;
        while (n < 60) begin
            if (n == 10)
                long_hold = 1'b1;
            case ($urandom_range(0, 9))
                0: send(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
                1, 2, 3, 4: send(cfar_pd_pkg::OP_READ, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: send(cfar_pd_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            n++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
